[design/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debouncer with long press and
// auto-repeat: field widths, register indexes, reset values, result layout.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // Field and register widths
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Stream data widths, padded to whole bytes, and the result width
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int RES_W      = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL  = 2'd2;

    // Register values after reset
    localparam logic [DELAY_W-1:0] DEBOUNCE_DELAY_RST   = 16'd50;
    localparam logic [DELAY_W-1:0] LONG_PRESS_DELAY_RST = 16'd1000;
    localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST  = 16'd300;

    // Deadline value that means disarmed
    localparam logic [TIME_W-1:0] DISARMED = '0;

    // Event flags of one poll, key_down in the lowest bit
    typedef struct packed {
        logic long_press;
        logic auto_repeat;
        logic up_after_long;
        logic key_up;
        logic key_down;
    } result_t;

endpackage

[design/button_debounce_long_press_repeat.sv]
// An accepted poll request is captured in the input register, evaluated by one
// pass of compare/add logic and held in the output register until taken.
// Throughput: one poll per cycle, sustained while m_axis_tready stays high.
// Reset (rst_n low, asynchronous): delays return to 50/1000/300 ms, the key
// reads released, all deadlines are disarmed and both stages are emptied.
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// Polled push-button debouncer reporting key-down, key-up, long-press and
// auto-repeat events, one result per poll request.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat
(
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write port
    input  logic                              cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdlp_pkg::DELAY_W-1:0]      cfg_data,

    // Poll requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] now_ms, [32] pin_level, [39:33] zero
    input  logic [bdlp_pkg::IN_DATA_W-1:0]    s_axis_tdata,

    // Poll results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] key_down, [1] key_up, [2] up_after_long, [3] auto_repeat,
    // [4] long_press, [7:5] zero
    output logic [bdlp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int TW = bdlp_pkg::TIME_W;
    localparam int DW = bdlp_pkg::DELAY_W;

    // Configuration registers
    logic [DW-1:0] debounce_delay_reg;
    logic [DW-1:0] long_press_delay_reg;
    logic [DW-1:0] repeat_interval_reg;

    // Key state
    logic          accepted_pressed_reg, accepted_pressed_next;
    logic [TW-1:0] debounce_deadline_reg, debounce_deadline_next;
    logic [TW-1:0] long_deadline_reg, long_deadline_next;
    logic [TW-1:0] repeat_deadline_reg, repeat_deadline_next;

    // Pipeline registers
    logic              in_valid_reg;
    logic [TW-1:0]     in_now_reg;
    logic              in_level_reg;
    logic              out_valid_reg;
    bdlp_pkg::result_t out_res_reg;
    bdlp_pkg::result_t res_next;

    logic advance;
    logic load_out;
    logic pressed;

    // Handshake: the output register frees when empty or taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign load_out      = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(bdlp_pkg::OUT_DATA_W - bdlp_pkg::RES_W){1'b0}}, out_res_reg};

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_delay_reg   <= bdlp_pkg::DEBOUNCE_DELAY_RST;
            long_press_delay_reg <= bdlp_pkg::LONG_PRESS_DELAY_RST;
            repeat_interval_reg  <= bdlp_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdlp_pkg::CFG_DEBOUNCE_DELAY:   debounce_delay_reg   <= cfg_data;
                bdlp_pkg::CFG_LONG_PRESS_DELAY: long_press_delay_reg <= cfg_data;
                bdlp_pkg::CFG_REPEAT_INTERVAL:  repeat_interval_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the poll request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_now_reg   <= s_axis_tdata[TW-1:0];
            in_level_reg <= s_axis_tdata[TW];
        end
    end

    // Evaluate one poll against the key state
    assign pressed = !in_level_reg;

    always_comb
    begin
        accepted_pressed_next  = accepted_pressed_reg;
        debounce_deadline_next = debounce_deadline_reg;
        long_deadline_next     = long_deadline_reg;
        repeat_deadline_next   = repeat_deadline_reg;
        res_next               = '0;

        if (in_now_reg >= debounce_deadline_reg)
        begin
            if (pressed == accepted_pressed_reg)
            begin
                // Held: fire repeat and long press when due
                if (pressed)
                begin
                    if ((repeat_deadline_reg != bdlp_pkg::DISARMED) &&
                        (in_now_reg >= repeat_deadline_reg))
                    begin
                        repeat_deadline_next = in_now_reg + {{(TW-DW){1'b0}}, repeat_interval_reg};
                        res_next.auto_repeat = 1'b1;
                    end
                    if ((long_deadline_reg != bdlp_pkg::DISARMED) &&
                        (in_now_reg >= long_deadline_reg))
                    begin
                        long_deadline_next  = bdlp_pkg::DISARMED;
                        res_next.long_press = 1'b1;
                    end
                end
            end
            else if (debounce_deadline_reg == bdlp_pkg::DISARMED)
            begin
                // Level changed: arm the debounce deadline
                debounce_deadline_next = in_now_reg + {{(TW-DW){1'b0}}, debounce_delay_reg};
            end
            else if (pressed)
            begin
                // Accept the press
                long_deadline_next     = in_now_reg + {{(TW-DW){1'b0}}, long_press_delay_reg};
                repeat_deadline_next   = in_now_reg + {{(TW-DW){1'b0}}, repeat_interval_reg};
                debounce_deadline_next = bdlp_pkg::DISARMED;
                accepted_pressed_next  = 1'b1;
                res_next.key_down      = 1'b1;
            end
            else
            begin
                // Accept the release
                res_next.up_after_long = (long_deadline_reg == bdlp_pkg::DISARMED);
                repeat_deadline_next   = bdlp_pkg::DISARMED;
                long_deadline_next     = bdlp_pkg::DISARMED;
                debounce_deadline_next = bdlp_pkg::DISARMED;
                accepted_pressed_next  = 1'b0;
                res_next.key_up        = 1'b1;
            end
        end
    end

    // Advance key state as the result moves into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_pressed_reg  <= 1'b0;
            debounce_deadline_reg <= bdlp_pkg::DISARMED;
            long_deadline_reg     <= bdlp_pkg::DISARMED;
            repeat_deadline_reg   <= bdlp_pkg::DISARMED;
        end
        else if (load_out)
        begin
            accepted_pressed_reg  <= accepted_pressed_next;
            debounce_deadline_reg <= debounce_deadline_next;
            long_deadline_reg     <= long_deadline_next;
            repeat_deadline_reg   <= repeat_deadline_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= res_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Press and release are never reported by the same poll
    a_no_down_and_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.key_down && out_res_reg.key_up))
        else $error("key_down and key_up in one result");

    // The long-press flag on release only rides with key_up
    a_after_long_with_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.up_after_long |-> out_res_reg.key_up)
        else $error("up_after_long without key_up");

    // Held events only come while the key stays accepted as pressed
    a_held_events_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.long_press || out_res_reg.auto_repeat)
        |-> accepted_pressed_reg)
        else $error("held event while released");

    // An accepted change disarms the debounce deadline
    a_accept_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (res_next.key_down || res_next.key_up)
        |=> debounce_deadline_reg == bdlp_pkg::DISARMED)
        else $error("debounce deadline left armed after accept");

    // State moves only when a result is loaded
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !load_out |=> $stable(accepted_pressed_reg) && $stable(long_deadline_reg))
        else $error("key state changed without a poll");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polled button debouncer. Drives poll requests
// that model a bouncing key held for random times, plus out-of-order and
// wrapping timestamps. Every accepted request is run through a local event
// predictor, and each result is compared flag by flag. Several delay settings
// are covered, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUIET_LIMIT = 500;
    localparam int PHASE_POLLS = 62;
    localparam int PRINT_LIMIT = 40;
    localparam int PAD_W       = bdlp_pkg::TIME_W - bdlp_pkg::DELAY_W;

    // Predicts the event flags of each poll and checks the results in order
    class poll_scoreboard;
        logic [bdlp_pkg::DELAY_W-1:0] deb_delay;
        logic [bdlp_pkg::DELAY_W-1:0] long_delay;
        logic [bdlp_pkg::DELAY_W-1:0] rep_interval;
        logic                         key_pressed;
        logic [bdlp_pkg::TIME_W-1:0]  deb_due;
        logic [bdlp_pkg::TIME_W-1:0]  long_due;
        logic [bdlp_pkg::TIME_W-1:0]  rep_due;
        bdlp_pkg::result_t            expected_events[$];
        int                           errors;
        int                           checked;
        int                           n_down;
        int                           n_up;
        int                           n_up_long;
        int                           n_repeat;
        int                           n_long;

        function new();
            deb_delay    = bdlp_pkg::DEBOUNCE_DELAY_RST;
            long_delay   = bdlp_pkg::LONG_PRESS_DELAY_RST;
            rep_interval = bdlp_pkg::REPEAT_INTERVAL_RST;
            key_pressed  = 1'b0;
            deb_due      = bdlp_pkg::DISARMED;
            long_due     = bdlp_pkg::DISARMED;
            rep_due      = bdlp_pkg::DISARMED;
        endfunction

        function void set_reg(logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                              logic [bdlp_pkg::DELAY_W-1:0] val);
            case (idx)
                bdlp_pkg::CFG_DEBOUNCE_DELAY:   deb_delay = val;
                bdlp_pkg::CFG_LONG_PRESS_DELAY: long_delay = val;
                bdlp_pkg::CFG_REPEAT_INTERVAL:  rep_interval = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        // Note an accepted poll request and queue the events it must raise
        function void predict_events(logic [bdlp_pkg::TIME_W-1:0] now, logic level);
            bdlp_pkg::result_t ev;
            logic              pressed;
            ev      = '0;
            pressed = ~level;
            if (now >= deb_due) begin
                if (pressed == key_pressed) begin
                    if (pressed) begin
                        if (rep_due != bdlp_pkg::DISARMED && now >= rep_due) begin
                            rep_due        = now + {{PAD_W{1'b0}}, rep_interval};
                            ev.auto_repeat = 1'b1;
                        end
                        if (long_due != bdlp_pkg::DISARMED && now >= long_due) begin
                            long_due      = bdlp_pkg::DISARMED;
                            ev.long_press = 1'b1;
                        end
                    end
                end
                else if (deb_due == bdlp_pkg::DISARMED) begin
                    deb_due = now + {{PAD_W{1'b0}}, deb_delay};
                end
                else if (pressed) begin
                    long_due    = now + {{PAD_W{1'b0}}, long_delay};
                    rep_due     = now + {{PAD_W{1'b0}}, rep_interval};
                    deb_due     = bdlp_pkg::DISARMED;
                    ev.key_down = 1'b1;
                    key_pressed = 1'b1;
                end
                else begin
                    ev.up_after_long = (long_due == bdlp_pkg::DISARMED);
                    rep_due          = bdlp_pkg::DISARMED;
                    long_due         = bdlp_pkg::DISARMED;
                    deb_due          = bdlp_pkg::DISARMED;
                    ev.key_up        = 1'b1;
                    key_pressed      = 1'b0;
                end
            end
            expected_events.push_back(ev);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_flag(string name, logic want, logic got);
            if (got !== want)
                report_mismatch($sformatf("result %0d: %s is %b, expected %b",
                                          checked, name, got, want));
        endtask

        // Compare one result request with the oldest expectation
        task check_result(logic [bdlp_pkg::OUT_DATA_W-1:0] data);
            bdlp_pkg::result_t got;
            bdlp_pkg::result_t want;
            got = bdlp_pkg::result_t'(data[bdlp_pkg::RES_W-1:0]);
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with no poll pending", data));
            end
            else begin
                want = expected_events.pop_front();
                compare_flag("key_down", want.key_down, got.key_down);
                compare_flag("key_up", want.key_up, got.key_up);
                compare_flag("up_after_long", want.up_after_long, got.up_after_long);
                compare_flag("auto_repeat", want.auto_repeat, got.auto_repeat);
                compare_flag("long_press", want.long_press, got.long_press);
                n_down    += want.key_down;
                n_up      += want.key_up;
                n_up_long += want.up_after_long;
                n_repeat  += want.auto_repeat;
                n_long    += want.long_press;
                checked++;
            end
        endtask
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [bdlp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [bdlp_pkg::DELAY_W-1:0]       cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // [31:0] now_ms, [32] pin_level, [39:33] zero
    logic [bdlp_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // [0] key_down, [1] key_up, [2] up_after_long, [3] auto_repeat,
    // [4] long_press, [7:5] zero
    logic [bdlp_pkg::OUT_DATA_W-1:0]    m_axis_tdata;

    poll_scoreboard                     book;
    int                                 quiet_cycles;
    int                                 polls_sent;
    int                                 settings_used;
    bit                                 gaps_on;
    logic [bdlp_pkg::TIME_W-1:0]        clock_ms;
    int unsigned                        cur_deb;
    int unsigned                        cur_long;
    int unsigned                        cur_rep;

    button_debounce_long_press_repeat i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Monitor both streams and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            book.predict_events(s_axis_tdata[bdlp_pkg::TIME_W-1:0],
                                s_axis_tdata[bdlp_pkg::TIME_W]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata);
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Send one poll request, with an optional gap ahead of it
    task automatic poll(logic [bdlp_pkg::TIME_W-1:0] now, logic level);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(bdlp_pkg::IN_DATA_W-bdlp_pkg::TIME_W-1){1'b0}}, level, now};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        polls_sent++;
    endtask

    // Write one register once every poll has been answered
    task automatic write_reg(logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                             logic [bdlp_pkg::DELAY_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        book.set_reg(idx, val);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_delays(int unsigned deb, int unsigned lng, int unsigned rep);
        write_reg(bdlp_pkg::CFG_DEBOUNCE_DELAY, deb[bdlp_pkg::DELAY_W-1:0]);
        write_reg(bdlp_pkg::CFG_LONG_PRESS_DELAY, lng[bdlp_pkg::DELAY_W-1:0]);
        write_reg(bdlp_pkg::CFG_REPEAT_INTERVAL, rep[bdlp_pkg::DELAY_W-1:0]);
        cur_deb  = deb;
        cur_long = lng;
        cur_rep  = rep;
        settings_used++;
    endtask

    // Move time forward; skip ahead when a debounce deadline sits far out
    task automatic advance(int unsigned span);
        logic [bdlp_pkg::TIME_W-1:0] gap;
        clock_ms = clock_ms + $urandom_range(0, span);
        gap      = book.deb_due - clock_ms;
        if (clock_ms < book.deb_due && gap > 4 * span + 4 * cur_deb + 1000)
            clock_ms = book.deb_due - $urandom_range(0, span);
    endtask

    function automatic int unsigned hold_span();
        case ($urandom_range(0, 2))
            0:       return cur_deb + 1;
            1:       return cur_rep + 1;
            default: return cur_long / 3 + 1;
        endcase
    endfunction

    // One key stroke: bounce in, hold, bounce out, rest released
    task automatic key_stroke();
        int n;
        int k;
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
            advance(cur_deb / 2 + 1);
            poll(clock_ms, 1'($urandom_range(0, 1)));
        end
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
            advance(hold_span());
            poll(clock_ms, 1'b0);
        end
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
            advance(cur_deb / 2 + 1);
            poll(clock_ms, 1'($urandom_range(0, 1)));
        end
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            advance(cur_deb + cur_rep / 4 + 1);
            poll(clock_ms, 1'b1);
        end
    endtask

    // Odd polls: jumps, time going back, near the wrap, stray levels
    task automatic stray_poll();
        case ($urandom_range(0, 7))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms = clock_ms - $urandom_range(0, cur_deb + cur_rep);
            3:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * (cur_deb + cur_rep));
            default: advance(cur_deb / 2 + 1);
        endcase
        poll(clock_ms, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(int count);
        int target;
        target = polls_sent + count;
        while (polls_sent < target) begin
            if ($urandom_range(0, 9) < 8)
                key_stroke();
            else
                stray_poll();
        end
    endtask

    // Hand-picked polls under the reset delays of 50/1000/300 ms
    task automatic run_directed();
        poll(32'd0, 1'b1);                 // idle released at time zero
        poll(32'hFFFF_FFFF, 1'b1);         // idle released at the latest time
        poll(32'd1000, 1'b0);              // arm debounce, time going back
        poll(32'd1030, 1'b1);              // still bouncing
        poll(32'd1050, 1'b0);              // key down
        poll(32'd1350, 1'b0);              // first auto-repeat
        poll(32'd2100, 1'b0);              // repeat and long press together
        poll(32'd2200, 1'b1);              // arm release
        poll(32'd2240, 1'b0);              // still bouncing
        poll(32'd2250, 1'b1);              // key up after long press
        poll(32'd3000, 1'b0);              // arm press
        poll(32'd3060, 1'b1);              // bounce back, deadline stays armed
        poll(32'd5000, 1'b0);              // accepted at once
        poll(32'd5100, 1'b1);              // arm release
        poll(32'd5150, 1'b1);              // key up before long press
        poll(32'hFFFF_FFCE, 1'b0);         // debounce deadline wraps to zero
        poll(32'hFFFF_FFD0, 1'b0);         // re-arm across the wrap
        poll(32'hFFFF_FFE0, 1'b0);         // key down, deadlines wrap
        poll(32'h0000_0010, 1'b0);         // held, nothing due
        poll(32'h0000_0200, 1'b0);         // repeat after the wrap
        poll(32'd0, 1'b1);                 // arm release
        poll(32'd60, 1'b1);                // key up, no long press
        poll(32'hFFFF_FBE6, 1'b0);         // arm press
        poll(32'hFFFF_FC18, 1'b0);         // long deadline wraps to zero
        poll(32'hFFFF_FC80, 1'b1);         // arm release, up follows later
    endtask

    initial
    begin
        book          = new();
        polls_sent    = 0;
        settings_used = 1;
        gaps_on       = 1'b1;
        clock_ms      = '0;
        cur_deb       = bdlp_pkg::DEBOUNCE_DELAY_RST;
        cur_long      = bdlp_pkg::LONG_PRESS_DELAY_RST;
        cur_rep       = bdlp_pkg::REPEAT_INTERVAL_RST;
        quiet_cycles  = 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= bdlp_pkg::CFG_DEBOUNCE_DELAY;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        clock_ms = 32'hFFFF_FD00;
        run_random(PHASE_POLLS);

        set_delays(1, 1, 1);
        run_random(PHASE_POLLS);
        set_delays(65535, 65535, 65535);
        run_random(PHASE_POLLS);
        set_delays(5, 40, 7);
        run_random(PHASE_POLLS);
        set_delays($urandom_range(1, 65535), $urandom_range(1, 65535),
                   $urandom_range(1, 65535));
        run_random(PHASE_POLLS);
        set_delays(20, 65535, 1);
        run_random(PHASE_POLLS);
        set_delays(65535, 1, 65535);
        run_random(PHASE_POLLS);

        // Final stretch at full rate on both sides
        gaps_on = 1'b0;
        set_delays(50, 1000, 300);
        run_random(PHASE_POLLS);

        // Drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d polls over %0d delay settings",
                 book.checked, polls_sent, settings_used);
        $display("Events: %0d down, %0d up (%0d after long), %0d repeat, %0d long press",
                 book.n_down, book.n_up, book.n_up_long, book.n_repeat, book.n_long);
        if (book.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
